// ===== rtl/amd_pkg.sv =====
// shared types, constants and helper functions of the min/max peak decimator
package amd_pkg;

    localparam int CNT_W      = 4;
    localparam int LEN_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 3;
    localparam int CH_W       = 5;
    localparam int STEP_W     = 38;
    localparam int POS_W      = 48;
    localparam int WEND_W     = 64;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0]         RESET_CHANNEL_COUNT = 4'd2;
    localparam logic [LEN_W-1:0]         RESET_WINDOW_LENGTH = 32'd28901376;
    localparam logic signed [BYTE_W-1:0] PEAK_HIGH_INIT      = -8'sd128;
    localparam logic signed [BYTE_W-1:0] PEAK_LOW_INIT       = 8'sd127;
    localparam logic [POS_W-1:0]         POS_MAX             = {POS_W{1'b1}};

    typedef struct packed {
        logic [CH_W-1:0]   chans;
        logic [STEP_W-1:0] step;
        logic              restart;
        logic [STEP_W-1:0] restart_step;
    } amd_cfg_t;

    // channel count clamped into 1..max_ch
    function automatic logic [CH_W-1:0] eff_channels(input logic [CNT_W-1:0] count,
                                                     input logic [CH_W-1:0]  max_ch);
        logic [CH_W-1:0] c;
        c = {1'b0, count};
        if (c == '0)
        begin
            c = CH_W'(1);
        end
        if (c > max_ch)
        begin
            c = max_ch;
        end
        return c;
    endfunction

    // 2 * channels * window length, q22.16
    function automatic logic [STEP_W-1:0] win_step(input logic [CH_W-1:0]  chans,
                                                   input logic [LEN_W-1:0] wl);
        return STEP_W'(wl) * STEP_W'({chans, 1'b0});
    endfunction

endpackage

// ===== rtl/amd_cfg.sv =====
// configuration registers and window step computation
module amd_cfg #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [amd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output amd_pkg::amd_cfg_t                cfg
);
    import amd_pkg::*;

    localparam logic [CH_W-1:0]   MAX_CH      = CH_W'(MAX_CHANNELS);
    localparam logic [CH_W-1:0]   RESET_CHANS = eff_channels(RESET_CHANNEL_COUNT, MAX_CH);
    localparam logic [STEP_W-1:0] RESET_STEP  = win_step(RESET_CHANS, RESET_WINDOW_LENGTH);

    logic [CNT_W-1:0]  count_reg;
    logic [LEN_W-1:0]  wl_reg;
    logic [CH_W-1:0]   chans_reg;
    logic [STEP_W-1:0] step_reg;

    logic              wr_count;
    logic              wr_len;
    logic [CNT_W-1:0]  count_next;
    logic [LEN_W-1:0]  wl_next;
    logic [CH_W-1:0]   chans_next;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        wr_count   = cfg_write_en && (cfg_index == REG_CHANNEL_COUNT);
        wr_len     = cfg_write_en && (cfg_index == REG_WINDOW_LENGTH);
        count_next = wr_count ? cfg_data[CNT_W-1:0] : count_reg;
        wl_next    = wr_len ? cfg_data[LEN_W-1:0] : wl_reg;
        chans_next = eff_channels(count_next, MAX_CH);
        step_next  = win_step(chans_next, wl_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_CHANNEL_COUNT;
            wl_reg    <= RESET_WINDOW_LENGTH;
            chans_reg <= RESET_CHANS;
            step_reg  <= RESET_STEP;
        end
        else if (wr_count || wr_len)
        begin
            count_reg <= count_next;
            wl_reg    <= wl_next;
            chans_reg <= chans_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cfg.chans        = chans_reg;
        cfg.step         = step_reg;
        cfg.restart      = wr_count || wr_len;
        cfg.restart_step = step_next;
    end

endmodule

// ===== rtl/amd_core.sv =====
// per-channel peak tracking, window bookkeeping and result register
module amd_core #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  amd_pkg::amd_cfg_t                   cfg,
    input  logic                                s1_valid,
    input  logic [amd_pkg::SAMPLE_W-1:0]        s1_sample,
    output logic                                take,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [amd_pkg::IDX_W-1:0]           channel_index,
    output logic signed [amd_pkg::BYTE_W-1:0]   peak_high,
    output logic signed [amd_pkg::BYTE_W-1:0]   peak_low,
    output logic                                last
);
    import amd_pkg::*;

    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CH_W-1:0]   MAX_CH      = CH_W'(MAX_CHANNELS);
    localparam logic [CH_W-1:0]   RESET_CHANS = eff_channels(RESET_CHANNEL_COUNT, MAX_CH);
    localparam logic [STEP_W-1:0] RESET_STEP  = win_step(RESET_CHANS, RESET_WINDOW_LENGTH);

    logic [CH_IDX_W-1:0]      cur_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [WEND_W-1:0]        wend_reg;
    logic                     closes_reg;
    logic signed [BYTE_W-1:0] high_reg [MAX_CHANNELS];
    logic signed [BYTE_W-1:0] low_reg  [MAX_CHANNELS];

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [BYTE_W-1:0] hi_out_reg;
    logic signed [BYTE_W-1:0] lo_out_reg;
    logic                     last_reg;

    logic [CH_IDX_W-1:0]      ch;
    logic                     is_last;
    logic                     closes;
    logic signed [BYTE_W-1:0] s;
    logic signed [BYTE_W-1:0] hi_new;
    logic signed [BYTE_W-1:0] lo_new;
    logic [POS_W:0]           frame_end;
    logic [WEND_W:0]          wend_sum;
    logic [WEND_W-1:0]        wend_next;
    logic [POS_W-1:0]         pos_next;
    logic [CH_IDX_W-1:0]      cur_next;

    always_comb
    begin
        take    = s1_valid && (!out_valid_reg || !out_stall);
        ch      = (CH_W'(cur_reg) >= cfg.chans) ? '0 : cur_reg;
        is_last = (CH_W'(ch) + CH_W'(1)) >= cfg.chans;
        cur_next = is_last ? '0 : ch + CH_IDX_W'(1);

        // a frame decides at its first channel whether it closes the window
        frame_end = {1'b0, pos_reg} + (POS_W + 1)'({cfg.chans, 1'b0});
        if (ch == '0)
        begin
            closes = frame_end >= (POS_W + 1)'(wend_reg[WEND_W-1:FRAC_W]);
        end
        else
        begin
            closes = closes_reg;
        end

        s      = s1_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
        hi_new = (s > high_reg[ch]) ? s : high_reg[ch];
        lo_new = (s < low_reg[ch]) ? s : low_reg[ch];

        wend_sum  = {1'b0, wend_reg} + (WEND_W + 1)'(cfg.step);
        wend_next = wend_sum[WEND_W] ? {WEND_W{1'b1}} : wend_sum[WEND_W-1:0];
        pos_next  = (pos_reg >= POS_MAX - POS_W'(1)) ? POS_MAX : pos_reg + POS_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            pos_reg    <= '0;
            wend_reg   <= WEND_W'(RESET_STEP);
            closes_reg <= 1'b0;
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                high_reg[k] <= PEAK_HIGH_INIT;
                low_reg[k]  <= PEAK_LOW_INIT;
            end
        end
        else if (cfg.restart)
        begin
            cur_reg    <= '0;
            pos_reg    <= '0;
            wend_reg   <= WEND_W'(cfg.restart_step);
            closes_reg <= 1'b0;
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                high_reg[k] <= PEAK_HIGH_INIT;
                low_reg[k]  <= PEAK_LOW_INIT;
            end
        end
        else if (take)
        begin
            cur_reg    <= cur_next;
            pos_reg    <= pos_next;
            closes_reg <= closes;
            if (closes)
            begin
                high_reg[ch] <= PEAK_HIGH_INIT;
                low_reg[ch]  <= PEAK_LOW_INIT;
                if (is_last)
                begin
                    wend_reg <= wend_next;
                end
            end
            else
            begin
                high_reg[ch] <= hi_new;
                low_reg[ch]  <= lo_new;
            end
        end
    end

    // result register: freed by the receiver or refilled by the next item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= closes;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && closes)
        begin
            idx_reg    <= IDX_W'(ch);
            hi_out_reg <= hi_new;
            lo_out_reg <= lo_new;
            last_reg   <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = idx_reg;
    assign peak_high     = hi_out_reg;
    assign peak_low      = lo_out_reg;
    assign last          = last_reg;

endmodule

// ===== rtl/audio_minmax_decimator_top.sv =====
// top level of the min/max peak decimator
// usage:
//  - input channel: pcm_sample with in_valid/in_stall, channels interleaved 0..C-1;
//    a transaction completes on a rising edge with in_valid high and in_stall low
//  - output channel: one window summary (channel_index, peak_high, peak_low, last)
//    per sample of a frame that closes a window, with out_valid/out_stall
//  - configuration: cfg_write_en, cfg_index, cfg_data; register 0 is the channel
//    count, register 1 the window length in q16.16; either write restarts the stream
//  - path: a sample's summary passes the input register, then the result register
//  - throughput: one sample per cycle unless out_stall holds a summary; the
//    per-sample compare, 49-bit window compare and 64-bit window advance sit
//    between the input and result registers
//  - reset clears the stream, the per-channel peaks and restores default settings
//  - while out_stall holds a summary, the input register still drains samples
//    until one is waiting; in_stall then rises until the summary is taken
module audio_minmax_decimator_top #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [amd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [amd_pkg::SAMPLE_W-1:0] pcm_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [amd_pkg::IDX_W-1:0]           channel_index,
    output logic signed [amd_pkg::BYTE_W-1:0]   peak_high,
    output logic signed [amd_pkg::BYTE_W-1:0]   peak_low,
    output logic                                last
);
    import amd_pkg::*;

    amd_cfg_t            cfg;
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                take;

    amd_cfg #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    assign in_stall = s1_valid_reg && !take;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || take)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_sample_reg <= pcm_sample;
        end
    end

    amd_core #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s1_valid      (s1_valid_reg),
        .s1_sample     (s1_sample_reg),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .peak_high     (peak_high),
        .peak_low      (peak_low),
        .last          (last)
    );

endmodule

// ===== rtl/amd_checker.sv =====
// port-level checks for the min/max peak decimator, bound to the top level
module amd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [amd_pkg::IDX_W-1:0]           channel_index,
    input logic signed [amd_pkg::BYTE_W-1:0]   peak_high,
    input logic signed [amd_pkg::BYTE_W-1:0]   peak_low,
    input logic                                last
);

    // a summary always includes at least one sample, so the peaks cannot cross
    a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_high >= peak_low))
        else $error("peak_high below peak_low");

    // input only backs up behind a held summary
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held summary");

    // a fresh summary follows its sample transaction through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("summary without a matching sample transaction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(channel_index)
            && $stable(peak_high) && $stable(peak_low) && $stable(last)))
        else $error("held summary changed");

endmodule

bind audio_minmax_decimator_top amd_checker u_amd_checker (.*);
